[rtl/core/vsd_pkg.sv]
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants of the packed index stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

  // Field widths of the two channels and of the decoding state.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SHIFT_W = 7;

  // Marker and framing bytes of the stream.
  localparam logic [BYTE_W-1:0] MARK_NOT_FOUND = 8'h40;
  localparam logic [BYTE_W-1:0] MARK_INVALID   = 8'h41;
  localparam logic [BYTE_W-1:0] MARK_SEQ_END   = 8'h42;

  // Once this many groups have been taken, later groups fall beyond bit 63.
  localparam logic [POS_W-1:0] POS_LIMIT = 4'd10;

  // Result kinds.
  localparam logic KIND_INDEX   = 1'b0;
  localparam logic KIND_SEQ_END = 1'b1;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index_value;
    logic [COUNT_W-1:0] found_count;
    logic [COUNT_W-1:0] not_found_count;
    logic [COUNT_W-1:0] invalid_count;
  } result_t;

endpackage

[rtl/core/vsd_if.sv]
// ----------------------------------------------------------------------------
// vsd_if
// Valid/ready channels of the decoder: the byte channel and the result channel.
// ----------------------------------------------------------------------------
interface vsd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [vsd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface vsd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [vsd_pkg::INDEX_W-1:0] index_value;
  logic [vsd_pkg::COUNT_W-1:0] found_count;
  logic [vsd_pkg::COUNT_W-1:0] not_found_count;
  logic [vsd_pkg::COUNT_W-1:0] invalid_count;

  modport source (
    output valid, output kind, output index_value, output found_count,
    output not_found_count, output invalid_count, input ready
  );
  modport sink (
    input valid, input kind, input index_value, input found_count,
    input not_found_count, input invalid_count, output ready
  );
endinterface

[rtl/core/varint_index_stream_decoder.sv]
// ----------------------------------------------------------------------------
// varint_index_stream_decoder
// Decodes a packed index stream into found indexes and per-sequence counts.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch carries one stream byte per request. Short bytes are literal
//   found indexes, bytes 0x40 and 0x41 count not-found and invalid markers,
//   byte 0x42 ends a sequence, and a byte with its top bit set opens a
//   little-endian base-128 number that closes on the first byte with the
//   top bit clear.
//   result_ch carries one request per found index (kind 0) and one per
//   sequence end (kind 1, with the three counts, which then restart at 0).
//   Throughput is one byte per cycle while the receiver is not stalled. A result
//   passes through the input register and then the output register before
//   it can be taken. The path is set by the 64-bit shift-or of one group.
//   Reset clears the open number and all counts, and empties both registers.
//   When the receiver stalls, the output register holds its result, the next
//   byte with a result waits in the input register, and byte_ch.ready falls
//   once both are full; nothing is dropped.
// ----------------------------------------------------------------------------
module varint_index_stream_decoder #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  vsd_byte_if.sink     byte_ch,
  vsd_result_if.source result_ch
);
  import vsd_pkg::*;

  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              consume;
  logic              emit;
  logic              res_ready;
  result_t           dec_result;
  result_t           out_result;

  // Input register.
  vsd_byte_stage u_byte_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (byte_ch.valid),
    .up_ready (byte_ch.ready),
    .up_byte  (byte_ch.in_byte),
    .consume  (consume),
    .valid    (stage_valid),
    .data     (stage_byte)
  );

  // Decoding state and logic.
  vsd_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (stage_valid),
    .byte_data  (stage_byte),
    .res_ready  (res_ready),
    .consume    (consume),
    .emit       (emit),
    .result     (dec_result)
  );

  // Output register.
  vsd_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (emit),
    .up_ready   (res_ready),
    .up_result  (dec_result),
    .valid      (result_ch.valid),
    .down_ready (result_ch.ready),
    .data       (out_result)
  );

  // Result fields onto the channel.
  assign result_ch.kind            = out_result.kind;
  assign result_ch.index_value     = out_result.index_value;
  assign result_ch.found_count     = out_result.found_count;
  assign result_ch.not_found_count = out_result.not_found_count;
  assign result_ch.invalid_count   = out_result.invalid_count;

endmodule

[rtl/core/vsd_byte_stage.sv]
// ----------------------------------------------------------------------------
// vsd_byte_stage
// Input register: holds one accepted byte until the decoder consumes it.
// ----------------------------------------------------------------------------
module vsd_byte_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [vsd_pkg::BYTE_W-1:0] up_byte,
  input  logic                       consume,
  output logic                       valid,
  output logic [vsd_pkg::BYTE_W-1:0] data
);
  import vsd_pkg::*;

  // The register frees up in the same cycle as its byte is consumed.
  assign up_ready = !valid || consume;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Byte payload.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_byte;
    end
  end

endmodule

[rtl/core/vsd_decode.sv]
// ----------------------------------------------------------------------------
// vsd_decode
// Decoding state and the single-pass logic that turns one byte into an
// optional result: base-128 accumulation, marker tallies and sequence end.
// ----------------------------------------------------------------------------
module vsd_decode #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  input  logic [vsd_pkg::BYTE_W-1:0] byte_data,
  input  logic                       res_ready,
  output logic                       consume,
  output logic                       emit,
  output vsd_pkg::result_t           result
);
  import vsd_pkg::*;

  logic [INDEX_W-1:0]    accumulator;
  logic [INDEX_W-1:0]    accumulator_next;
  logic [POS_W-1:0]      group_position;
  logic [POS_W-1:0]      group_position_next;
  logic                  number_open;
  logic                  number_open_next;
  logic [COUNT_BITS-1:0] found_tally;
  logic [COUNT_BITS-1:0] found_tally_next;
  logic [COUNT_BITS-1:0] not_found_tally;
  logic [COUNT_BITS-1:0] not_found_tally_next;
  logic [COUNT_BITS-1:0] invalid_tally;
  logic [COUNT_BITS-1:0] invalid_tally_next;

  logic [SHIFT_W-1:0]    shift_amt;
  logic [INDEX_W-1:0]    group_wide;
  logic [INDEX_W-1:0]    merged;
  logic [POS_W-1:0]      pos_bumped;
  logic [COUNT_BITS-1:0] found_inc;
  logic [COUNT_BITS-1:0] not_found_inc;
  logic [COUNT_BITS-1:0] invalid_inc;

  // The group's bit offset is seven times its position.
  assign shift_amt  = SHIFT_W'({group_position, 3'b000}) - SHIFT_W'(group_position);
  assign group_wide = INDEX_W'(byte_data[GROUP_W-1:0]);
  assign merged     = (group_position < POS_LIMIT) ?
                      (accumulator | (group_wide << shift_amt)) : accumulator;
  assign pos_bumped = (group_position < POS_LIMIT) ? group_position + 1'b1
                                                   : group_position;

  // Saturating tally increments.
  assign found_inc     = (&found_tally) ? found_tally : found_tally + 1'b1;
  assign not_found_inc = (&not_found_tally) ? not_found_tally : not_found_tally + 1'b1;
  assign invalid_inc   = (&invalid_tally) ? invalid_tally : invalid_tally + 1'b1;

  // A byte moves on unless its result has nowhere to go.
  assign consume = byte_valid && (!emit || res_ready);

  // Next state and result for the byte in the input register.
  always_comb begin
    accumulator_next     = accumulator;
    group_position_next  = group_position;
    number_open_next     = number_open;
    found_tally_next     = found_tally;
    not_found_tally_next = not_found_tally;
    invalid_tally_next   = invalid_tally;
    emit                 = 1'b0;
    result               = '0;
    result.kind          = KIND_INDEX;

    if (number_open) begin
      accumulator_next    = merged;
      group_position_next = pos_bumped;
      if (!byte_data[BYTE_W-1]) begin
        number_open_next   = 1'b0;
        found_tally_next   = found_inc;
        emit               = byte_valid;
        result.index_value = merged;
      end
    end else begin
      unique case (byte_data)
        MARK_NOT_FOUND: begin
          not_found_tally_next = not_found_inc;
        end
        MARK_INVALID: begin
          invalid_tally_next = invalid_inc;
        end
        MARK_SEQ_END: begin
          emit                   = byte_valid;
          result.kind            = KIND_SEQ_END;
          result.found_count     = COUNT_W'(found_tally);
          result.not_found_count = COUNT_W'(not_found_tally);
          result.invalid_count   = COUNT_W'(invalid_tally);
          found_tally_next       = '0;
          not_found_tally_next   = '0;
          invalid_tally_next     = '0;
        end
        default: begin
          if (!byte_data[BYTE_W-1]) begin
            // A short byte is itself a found index.
            found_tally_next   = found_inc;
            emit               = byte_valid;
            result.index_value = INDEX_W'(byte_data);
          end else begin
            // Open a new number with its lowest group.
            accumulator_next    = group_wide;
            group_position_next = POS_W'(1);
            number_open_next    = 1'b1;
          end
        end
      endcase
    end
  end

  // State registers, updated only when the byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      group_position  <= '0;
      number_open     <= 1'b0;
      found_tally     <= '0;
      not_found_tally <= '0;
      invalid_tally   <= '0;
    end else if (consume) begin
      accumulator     <= accumulator_next;
      group_position  <= group_position_next;
      number_open     <= number_open_next;
      found_tally     <= found_tally_next;
      not_found_tally <= not_found_tally_next;
      invalid_tally   <= invalid_tally_next;
    end
  end

  // An open number always holds at least its first group.
  a_open_has_group: assert property (@(posedge clk) disable iff (rst)
    number_open |-> group_position != '0)
    else $error("number open with no group taken");

  // A sequence end leaves all tallies cleared.
  a_seq_end_clears: assert property (@(posedge clk) disable iff (rst)
    consume && emit && result.kind == KIND_SEQ_END |=>
      found_tally == '0 && not_found_tally == '0 && invalid_tally == '0)
    else $error("tallies not cleared after sequence end");

  // A delivered index is always counted.
  a_index_counted: assert property (@(posedge clk) disable iff (rst)
    consume && emit && result.kind == KIND_INDEX |=> found_tally != '0)
    else $error("found index not counted");

  // Marker bytes inside a number never touch the marker tallies.
  a_open_keeps_markers: assert property (@(posedge clk) disable iff (rst)
    consume && number_open |=> $stable(not_found_tally) && $stable(invalid_tally))
    else $error("marker tally changed inside a number");

endmodule

[rtl/core/vsd_result_reg.sv]
// ----------------------------------------------------------------------------
// vsd_result_reg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vsd_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  vsd_pkg::result_t up_result,
  output logic             valid,
  input  logic             down_ready,
  output vsd_pkg::result_t data
);
  import vsd_pkg::*;

  // Space is free when empty or when the held result leaves this cycle.
  assign up_ready = !valid || down_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_result;
    end
  end

endmodule
